[design/srt_pkg.sv]
// Package for the sorted record table: sizes, codes, command and status types.
// Used by every module of the block but srt_ram; depends on nothing.
`timescale 1ns / 1ps
package srt_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 10;
  localparam int ID_W     = 32;
  localparam int GRADE_W  = 10;
  localparam int SLOTS    = 2 * CAPACITY;
  localparam int ADDR_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = ID_W + KEY_BITS;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_SEARCH  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_LIST    = 3'd3,
    OP_MERGE_DN = 3'd4,
    OP_MERGE_UP = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUP_KEPT  = 3'd4,
    ST_NEED_BOTH = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SC_RD, S_SC_EV, S_RM_RD, S_RM_WR, S_IN_RD, S_IN_EV,
    S_LS_RD, S_LS_EV, S_MG_RD0, S_MG_LD0, S_MG_RD1, S_MG_LD1, S_MG_CMP
  } state_e;

  typedef enum logic [2:0] {J_HOLD, J_INC, J_DEC, J_CNTM1} jop_e;
  typedef enum logic [2:0] {RD_J, RD_JP1, RD_JM1, RD_SIDE0, RD_SIDE1} rsel_e;
  typedef enum logic [1:0] {REC_NONE, REC_RDATA, REC_NEW, REC_HEAD} rec_e;

  typedef struct packed {
    logic    load;
    jop_e    jop;
    rsel_e   rsel;
    logic    wr_en;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    r_dec0;
    logic    r_dec1;
    logic    h_ld0;
    logic    h_ld1;
    logic    emit;
    status_e code;
    rec_e    rec;
    logic    last;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic ow;
    logic cnt_zero;
    logic either_empty;
    logic full;
    logic j_end;
    logic jp1_end;
    logic j_zero;
    logic id_match;
    logic key_gt;
    logic take0;
    logic merge_last;
    logic r0_more;
    logic r1_more;
  } stat_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic bank,
                                                 input logic [CNT_W-1:0] idx);
    slot_addr = ADDR_W'(idx) + (bank ? ADDR_W'(CAPACITY) : '0);
  endfunction

endpackage

[design/srt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/srt_ctrl.sv]
// Controller state machine: sequences scans, shifts, listing and merge.
// Depends on srt_pkg; drives the datapath by cmd_t, reads stat_t.
`timescale 1ns / 1ps
module srt_ctrl import srt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t st_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   init_q, init_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DISP;
      end
      S_DISP: begin
        case (st_i.op)
          OP_INSERT: state_d = S_SC_RD;
          OP_SEARCH, OP_DELETE: state_d = st_i.cnt_zero ? S_IDLE : S_SC_RD;
          OP_LIST: state_d = st_i.cnt_zero ? S_IDLE : S_LS_RD;
          OP_MERGE_DN, OP_MERGE_UP: begin
            state_d = st_i.either_empty ? S_IDLE : S_MG_RD0;
            init_d  = 1'b1;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SC_RD: begin
        if (!st_i.j_end) state_d = S_SC_EV;
        else if (st_i.op == OP_INSERT && !st_i.full) state_d = S_IN_RD;
        else state_d = S_IDLE;
      end
      S_SC_EV: begin
        if (!st_i.id_match) state_d = S_SC_RD;
        else if ((st_i.op == OP_INSERT && st_i.ow) || st_i.op == OP_DELETE)
          state_d = S_RM_RD;
        else state_d = S_IDLE;
      end
      S_RM_RD: begin
        if (!st_i.jp1_end) state_d = S_RM_WR;
        else state_d = (st_i.op == OP_INSERT) ? S_IN_RD : S_IDLE;
      end
      S_RM_WR: state_d = S_RM_RD;
      S_IN_RD: state_d = st_i.j_zero ? S_IDLE : S_IN_EV;
      S_IN_EV: state_d = st_i.key_gt ? S_IDLE : S_IN_RD;
      S_LS_RD: state_d = S_LS_EV;
      S_LS_EV: state_d = st_i.jp1_end ? S_IDLE : S_LS_RD;
      S_MG_RD0: state_d = S_MG_LD0;
      S_MG_LD0: state_d = init_q ? S_MG_RD1 : S_MG_CMP;
      S_MG_RD1: state_d = S_MG_LD1;
      S_MG_LD1: begin
        state_d = S_MG_CMP;
        init_d  = 1'b0;
      end
      S_MG_CMP: begin
        if (st_i.merge_last) state_d = S_IDLE;
        else if (st_i.take0 && st_i.r0_more) state_d = S_MG_RD0;
        else if (!st_i.take0 && st_i.r1_more) state_d = S_MG_RD1;
        else state_d = S_MG_CMP;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.jop  = J_HOLD;
    cmd_o.rsel = RD_J;
    cmd_o.code = ST_OK;
    cmd_o.rec  = REC_NONE;
    cmd_o.last = 1'b1;
    case (state_q)
      S_IDLE: cmd_o.load = start;
      S_DISP: begin
        case (st_i.op)
          OP_SEARCH, OP_DELETE, OP_LIST: begin
            cmd_o.emit = st_i.cnt_zero;
            cmd_o.code = ST_EMPTY;
          end
          OP_MERGE_DN, OP_MERGE_UP: begin
            cmd_o.emit = st_i.either_empty;
            cmd_o.code = ST_NEED_BOTH;
          end
          default: cmd_o.emit = 1'b0;
        endcase
      end
      S_SC_RD: begin
        if (st_i.j_end) begin
          if (st_i.op != OP_INSERT) begin
            cmd_o.emit = 1'b1;
            cmd_o.code = ST_NOT_FOUND;
          end else if (st_i.full) begin
            cmd_o.emit = 1'b1;
            cmd_o.code = ST_FULL;
          end
        end
      end
      S_SC_EV: begin
        if (!st_i.id_match) begin
          cmd_o.jop = J_INC;
        end else if (st_i.op == OP_INSERT) begin
          cmd_o.emit = !st_i.ow;
          cmd_o.code = ST_DUP_KEPT;
          cmd_o.rec  = REC_RDATA;
        end else begin
          cmd_o.emit = 1'b1;
          cmd_o.rec  = REC_RDATA;
        end
      end
      S_RM_RD: begin
        cmd_o.rsel = RD_JP1;
        if (st_i.jp1_end) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.jop     = J_CNTM1;
        end
      end
      S_RM_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.jop   = J_INC;
      end
      S_IN_RD: begin
        cmd_o.rsel = RD_JM1;
        if (st_i.j_zero) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.rec     = REC_NEW;
        end
      end
      S_IN_EV: begin
        cmd_o.wr_en = 1'b1;
        if (st_i.key_gt) begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.rec     = REC_NEW;
        end else begin
          cmd_o.jop = J_DEC;
        end
      end
      S_LS_EV: begin
        cmd_o.emit = 1'b1;
        cmd_o.rec  = REC_RDATA;
        cmd_o.last = st_i.jp1_end;
        cmd_o.jop  = J_INC;
      end
      S_MG_RD0: cmd_o.rsel = RD_SIDE0;
      S_MG_LD0: cmd_o.h_ld0 = 1'b1;
      S_MG_RD1: cmd_o.rsel = RD_SIDE1;
      S_MG_LD1: cmd_o.h_ld1 = 1'b1;
      S_MG_CMP: begin
        cmd_o.emit   = 1'b1;
        cmd_o.rec    = REC_HEAD;
        cmd_o.last   = st_i.merge_last;
        cmd_o.r_dec0 = st_i.take0;
        cmd_o.r_dec1 = !st_i.take0;
      end
      default: cmd_o.load = 1'b0;
    endcase
  end

endmodule

[design/srt_dpath.sv]
// Datapath: request registers, bank counts, walk pointers, merge heads,
// record RAM and the result register. Depends on srt_pkg and srt_ram.
`timescale 1ns / 1ps
module srt_dpath import srt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         opcode_i,
  input  logic               bank_i,
  input  logic [ID_W-1:0]    student_id_i,
  input  logic [GRADE_W-1:0] grade_i,
  input  logic               overwrite_i,
  input  cmd_t               cmd_i,
  output stat_t              st_o,
  output logic               strobe_o,
  output logic [2:0]         status_o,
  output logic               record_valid_o,
  output logic               record_bank_o,
  output logic [ID_W-1:0]    record_id_o,
  output logic [GRADE_W-1:0] record_grade_o,
  output logic               last_o
);

  op_e                 op_q;
  logic                bank_q, ow_q;
  logic [ID_W-1:0]     id_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CNT_W-1:0]    cnt_q [2];
  logic [CNT_W-1:0]    j_q, r0_q, r1_q;
  logic [ID_W-1:0]     h0_id_q, h1_id_q;
  logic [KEY_BITS-1:0] h0_key_q, h1_key_q;

  logic                strobe_q, recv_q, recb_q, last_q;
  logic [2:0]          status_q;
  logic [ID_W-1:0]     recid_q;
  logic [GRADE_W-1:0]  recgr_q;

  logic [ADDR_W-1:0]   raddr, waddr;
  logic [ENTRY_W-1:0]  rdata, wdata;
  logic [ID_W-1:0]     rd_id;
  logic [KEY_BITS-1:0] rd_key;
  logic [CNT_W-1:0]    n, jp1, idx0, idx1;
  logic                dn;

  assign n      = cnt_q[bank_q];
  assign rd_id  = rdata[ENTRY_W-1:KEY_BITS];
  assign rd_key = rdata[KEY_BITS-1:0];
  assign jp1    = j_q + CNT_W'(1);
  assign dn     = (op_q == OP_MERGE_DN);
  // descending walks from the head, ascending from the tail
  assign idx0   = dn ? (cnt_q[0] - r0_q) : (r0_q - CNT_W'(1));
  assign idx1   = dn ? (cnt_q[1] - r1_q) : (r1_q - CNT_W'(1));

  always_comb begin
    case (cmd_i.rsel)
      RD_JP1:   raddr = slot_addr(bank_q, jp1);
      RD_JM1:   raddr = slot_addr(bank_q, j_q - CNT_W'(1));
      RD_SIDE0: raddr = slot_addr(1'b0, idx0);
      RD_SIDE1: raddr = slot_addr(1'b1, idx1);
      default:  raddr = slot_addr(bank_q, j_q);
    endcase
  end

  assign waddr = slot_addr(bank_q, j_q);
  assign wdata = cmd_i.wr_new ? {id_q, key_q} : rdata;

  srt_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // status
  always_comb begin
    st_o.op           = op_q;
    st_o.ow           = ow_q;
    st_o.cnt_zero     = (n == '0);
    st_o.either_empty = (cnt_q[0] == '0) || (cnt_q[1] == '0);
    st_o.full         = (n == CNT_W'(CAPACITY));
    st_o.j_end        = (j_q == n);
    st_o.jp1_end      = (jp1 >= n);
    st_o.j_zero       = (j_q == '0);
    st_o.id_match     = (rd_id == id_q);
    st_o.key_gt       = (rd_key > key_q);
    if (r0_q == '0)      st_o.take0 = 1'b0;
    else if (r1_q == '0) st_o.take0 = 1'b1;
    else if (dn)         st_o.take0 = (h0_key_q > h1_key_q);
    else                 st_o.take0 = (h0_key_q <= h1_key_q);
    st_o.merge_last   = (({1'b0, r0_q} + {1'b0, r1_q}) == (CNT_W + 1)'(1));
    st_o.r0_more      = (r0_q > CNT_W'(1));
    st_o.r1_more      = (r1_q > CNT_W'(1));
  end

  // control-relevant counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) cnt_q[bank_q] <= n + CNT_W'(1);
      else if (cmd_i.cnt_dec) cnt_q[bank_q] <= n - CNT_W'(1);
      strobe_q <= cmd_i.emit;
    end
  end

  // request, pointers and heads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(opcode_i);
      bank_q <= bank_i;
      id_q   <= student_id_i;
      key_q  <= KEY_BITS'(grade_i);
      ow_q   <= overwrite_i;
      j_q    <= '0;
      r0_q   <= cnt_q[0];
      r1_q   <= cnt_q[1];
    end else begin
      case (cmd_i.jop)
        J_INC:   j_q <= jp1;
        J_DEC:   j_q <= j_q - CNT_W'(1);
        J_CNTM1: j_q <= n - CNT_W'(1);
        default: j_q <= j_q;
      endcase
      if (cmd_i.r_dec0) r0_q <= r0_q - CNT_W'(1);
      if (cmd_i.r_dec1) r1_q <= r1_q - CNT_W'(1);
    end
    if (cmd_i.h_ld0) begin
      h0_id_q  <= rd_id;
      h0_key_q <= rd_key;
    end
    if (cmd_i.h_ld1) begin
      h1_id_q  <= rd_id;
      h1_key_q <= rd_key;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.code;
      last_q   <= cmd_i.last;
      case (cmd_i.rec)
        REC_RDATA: begin
          recv_q  <= 1'b1;
          recb_q  <= bank_q;
          recid_q <= rd_id;
          recgr_q <= GRADE_W'(rd_key);
        end
        REC_NEW: begin
          recv_q  <= 1'b1;
          recb_q  <= bank_q;
          recid_q <= id_q;
          recgr_q <= GRADE_W'(key_q);
        end
        REC_HEAD: begin
          recv_q  <= 1'b1;
          recb_q  <= !st_o.take0;
          recid_q <= st_o.take0 ? h0_id_q : h1_id_q;
          recgr_q <= GRADE_W'(st_o.take0 ? h0_key_q : h1_key_q);
        end
        default: begin
          recv_q  <= 1'b0;
          recb_q  <= 1'b0;
          recid_q <= '0;
          recgr_q <= '0;
        end
      endcase
    end
  end

  assign strobe_o       = strobe_q;
  assign status_o       = status_q;
  assign record_valid_o = recv_q;
  assign record_bank_o  = recb_q;
  assign record_id_o    = recid_q;
  assign record_grade_o = recgr_q;
  assign last_o         = last_q;

endmodule

[design/sorted_record_table.sv]
// Top level of the sorted record table; depends on srt_pkg, srt_ctrl, srt_dpath.
// Each request takes a dispatch step, then a read and an evaluate or write step per entry
// scanned or shifted; list reads and emits each entry; merge reads and loads both heads,
// then compares for each result. The single RAM read port sets these steps.
// Throughput: one transfer at a time, the next once busy drops; results leave from a
// register and the receiver cannot stall. Reset clears controller state, bank counts and
// the strobe only; the RAM is never cleared.
`timescale 1ns / 1ps
module sorted_record_table import srt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic               bank_i,
  input  logic [ID_W-1:0]    student_id_i,
  input  logic [GRADE_W-1:0] grade_i,
  input  logic               overwrite_i,
  output logic               strobe_o,
  output logic [2:0]         status_o,
  output logic               record_valid_o,
  output logic               record_bank_o,
  output logic [ID_W-1:0]    record_id_o,
  output logic [GRADE_W-1:0] record_grade_o,
  output logic               last_o
);

  // controller only sees a status snapshot; datapath acts on commands
  cmd_t  cmd;
  stat_t st;

  srt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  // each transfer on the result side is one strobe cycle
  srt_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .bank_i         (bank_i),
    .student_id_i   (student_id_i),
    .grade_i        (grade_i),
    .overwrite_i    (overwrite_i),
    .cmd_i          (cmd),
    .st_o           (st),
    .strobe_o       (strobe_o),
    .status_o       (status_o),
    .record_valid_o (record_valid_o),
    .record_bank_o  (record_bank_o),
    .record_id_o    (record_id_o),
    .record_grade_o (record_grade_o),
    .last_o         (last_o)
  );

endmodule

[design/srt_checker.sv]
// Port-level checks for the sorted record table, bound to the top level.
// Depends on srt_pkg.
`timescale 1ns / 1ps
module srt_checker import srt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               strobe_o,
  input logic [2:0]         status_o,
  input logic               record_valid_o,
  input logic               record_bank_o,
  input logic [ID_W-1:0]    record_id_o,
  input logic [GRADE_W-1:0] record_grade_o,
  input logic               last_o
);

  a_empty_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !record_valid_o |->
      record_id_o == '0 && record_grade_o == '0 && !record_bank_o)
    else $error("record fields not zero without record");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o != ST_OK |-> last_o)
    else $error("error status not on a single final transfer");

  a_ok_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !record_valid_o |-> status_o != ST_OK)
    else $error("ok status without record");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy)
    else $error("idle before final transfer");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request not worked on");

endmodule

bind sorted_record_table srt_checker u_chk (.*);
